/* hw/rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and lookup functions shared by the base64 text decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CHAR   = 2'd2,
    ST_PRINT  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BC_NONE = 2'd0,
    BC_ONE  = 2'd1,
    BC_ESC  = 2'd2
  } byte_cnt_t;

  typedef struct packed {
    byte_cnt_t  cnt;
    logic [7:0] data;
    logic       has_status;
    status_t    status;
  } bundle_t;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] NL_CHAR    = 8'h0A;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;

  // {valid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r = {1'b1, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r = {1'b1, 6'(ch - 8'h47)};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 6'(ch + 8'h04)};
    end else if (ch == 8'h2B) begin
      r = {1'b1, 6'h3E};
    end else if (ch == 8'h2F) begin
      r = {1'b1, 6'h3F};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h5C;
      2'd1: r = 8'h78;
      default: r = 8'h32;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/b64d_char_if.sv */
// ----------------------------------------------------------------------------
// b64d_char_if
// Character channel: one base64 character per beat, with end-of-string flag.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

/* hw/rtl/b64d_res_if.sv */
// ----------------------------------------------------------------------------
// b64d_res_if
// Result channel: decoded bytes and end-of-string status, one per beat.
// ----------------------------------------------------------------------------
interface b64d_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       run_last;

  modport source (output valid, output kind, output out_byte, output status,
                  output run_last, input ready);
  modport sink (input valid, input kind, input out_byte, input status,
                input run_last, output ready);
endinterface

/* hw/rtl/b64d_decode.sv */
// ----------------------------------------------------------------------------
// b64d_decode
// Per-character decode: sextet lookup, bit accumulator, length and pad
// tracking, first-error capture; builds the result bundle for each beat.
// ----------------------------------------------------------------------------
module b64d_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        ch,
  input  logic              last,
  output b64d_pkg::bundle_t bundle,
  output logic              bundle_valid
);
  import b64d_pkg::*;

  logic [11:0] acc, acc_next;
  logic [2:0]  held, held_next;
  logic [1:0]  len_mod, len_mod_next;
  logic        len_four, len_four_next;
  logic [1:0]  pads, pads_next;
  status_t     err, err_next, err_fin;

  logic [6:0]  sx;
  logic [11:0] acc_shift;
  logic [3:0]  held_sum;
  logic [3:0]  held_sub;
  logic [7:0]  dec_byte;
  byte_cnt_t   cnt;

  always_comb begin
    sx            = sextet_of(ch);
    acc_shift     = {acc[5:0], sx[5:0]};
    held_sum      = {1'b0, held} + 4'd6;
    held_sub      = held_sum - 4'd8;
    dec_byte      = 8'(acc_shift >> held_sub[2:0]);
    len_mod_next  = len_mod + 2'd1;
    len_four_next = len_four | (len_mod_next == 2'd0);
    pads_next     = pads;
    err_next      = err;
    acc_next      = acc;
    held_next     = held;
    cnt           = BC_NONE;

    if (ch == PAD_CHAR) begin
      if (pads != 2'd3) pads_next = pads + 2'd1;
    end else if (!sx[6] || pads != 2'd0) begin
      if (err == ST_OK) err_next = ST_CHAR;
    end else if (err == ST_OK) begin
      acc_next = acc_shift;
      if (held_sum >= 4'd8) begin
        held_next = held_sub[2:0];
        if (dec_byte == QUOTE_CHAR) begin
          cnt = BC_ESC;
        end else if (dec_byte == TAB_CHAR || dec_byte == NL_CHAR ||
                     (dec_byte >= PRINT_LO && dec_byte <= PRINT_HI)) begin
          cnt = BC_ONE;
        end else begin
          err_next = ST_PRINT;
        end
      end else begin
        held_next = held_sum[2:0];
      end
    end

    err_fin = err_next;
    if (pads_next == 2'd3 && err_next == ST_OK) err_fin = ST_CHAR;

    bundle.cnt        = cnt;
    bundle.data       = dec_byte;
    bundle.has_status = last;
    bundle.status     = (len_mod_next != 2'd0 || !len_four_next) ? ST_LENGTH : err_fin;
    bundle_valid      = (cnt != BC_NONE) || last;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      acc      <= '0;
      held     <= '0;
      len_mod  <= '0;
      len_four <= 1'b0;
      pads     <= '0;
      err      <= ST_OK;
    end else if (take) begin
      acc      <= acc_next;
      held     <= held_next;
      len_mod  <= len_mod_next;
      len_four <= len_four_next;
      pads     <= pads_next;
      err      <= err_next;
    end
  end

endmodule

/* hw/rtl/b64d_emit.sv */
// ----------------------------------------------------------------------------
// b64d_emit
// Holds one result bundle and drains it into the output register, one result beat
// per cycle while results are taken; takes the next bundle as this one finishes.
// ----------------------------------------------------------------------------
module b64d_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b64d_pkg::bundle_t bundle,
  output logic              ready,
  b64d_res_if.source        dout
);
  import b64d_pkg::*;

  bundle_t    pend;
  logic       pend_valid;
  logic [2:0] idx;
  logic       out_valid;
  logic       out_kind;
  logic [7:0] out_data;
  logic [1:0] out_status;
  logic       out_last;

  logic [2:0] nbytes;
  logic [2:0] last_idx;
  logic       advance;
  logic       pend_done;
  logic       r_kind;
  logic [7:0] r_data;
  logic [1:0] r_status;

  always_comb begin
    case (pend.cnt)
      BC_ONE:  nbytes = 3'd1;
      BC_ESC:  nbytes = 3'd4;
      default: nbytes = 3'd0;
    endcase
    last_idx  = nbytes + {2'b00, pend.has_status} - 3'd1;
    advance   = pend_valid && (!out_valid || dout.ready);
    pend_done = advance && (idx == last_idx);
    ready     = !pend_valid || pend_done;
    if (idx < nbytes) begin
      r_kind   = 1'b0;
      r_data   = (pend.cnt == BC_ONE) ? pend.data : esc_byte(idx[1:0]);
      r_status = ST_OK;
    end else begin
      r_kind   = 1'b1;
      r_data   = 8'h00;
      r_status = pend.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (load) begin
        pend_valid <= 1'b1;
      end else if (pend_done) begin
        pend_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= pend_done ? 3'd0 : idx + 3'd1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) pend <= bundle;
    if (advance) begin
      out_kind   <= r_kind;
      out_data   <= r_data;
      out_status <= r_status;
      out_last   <= (idx == last_idx);
    end
  end

  assign dout.valid    = out_valid;
  assign dout.kind     = out_kind;
  assign dout.out_byte = out_data;
  assign dout.status   = out_status;
  assign dout.run_last = out_last;

endmodule

/* hw/rtl/base64_text_decoder.sv */
// Path: a character's bundle is held in the emit stage, then registered at output.
// Throughput: one character per cycle while each yields at most one result and
// results are taken; a quote escape (four bytes) or an end-of-string status holds
// the next character until the single result register drains the bundle stage.
// Reset: synchronous; clears decoder state and empties both stages.
// ----------------------------------------------------------------------------
// base64_text_decoder
// Streaming base64 text decoder with printable check and quote escaping.
// ----------------------------------------------------------------------------
module base64_text_decoder (
  input logic         clk,
  input logic         rst,
  b64d_char_if.sink   chars,
  b64d_res_if.source  results
);
  import b64d_pkg::*;

  bundle_t bundle;
  logic    bundle_valid;
  logic    take;
  logic    emit_ready;

  assign chars.ready = emit_ready;
  assign take        = chars.valid && emit_ready;

  b64d_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .ch           (chars.in_char),
    .last         (chars.in_last),
    .bundle       (bundle),
    .bundle_valid (bundle_valid)
  );

  b64d_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (take && bundle_valid),
    .bundle (bundle),
    .ready  (emit_ready),
    .dout   (results)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives base64 strings into base64_text_decoder and checks every result beat
// against a predictor of the decoder. The strings are well-formed encodings of
// printable text, broken strings and noise. Both channels idle at random.
// ----------------------------------------------------------------------------
import b64d_pkg::*;

typedef logic [7:0] octet_q [$];

typedef struct packed {
  logic       kind;
  logic [7:0] out_byte;
  status_t    status;
  logic       run_last;
} result_t;

class text_scoreboard;
  localparam logic [7:0] ESC_BACKSLASH = 8'h5C;
  localparam logic [7:0] ESC_X         = 8'h78;
  localparam logic [7:0] ESC_TWO       = 8'h32;

  logic [11:0] acc;
  int          held;
  logic [1:0]  len_mod;
  logic        len_four;
  logic [1:0]  pads;
  status_t     err;
  result_t     pending_results [$];
  int          fail_count;

  function new();
    clear_string();
    fail_count = 0;
  endfunction

  function void clear_string();
    acc      = '0;
    held     = 0;
    len_mod  = '0;
    len_four = 1'b0;
    pads     = '0;
    err      = ST_OK;
  endfunction

  // {valid, value}
  function logic [6:0] sextet_value(logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - 8'd65)};
    if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - 8'd71)};
    if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch + 8'd4)};
    if (ch == "+") return {1'b1, 6'd62};
    if (ch == "/") return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function void flag_error(status_t code);
    if (err == ST_OK) err = code;
  endfunction

  function void push_result(logic kind, logic [7:0] b, status_t st);
    result_t r;
    r.kind     = kind;
    r.out_byte = b;
    r.status   = st;
    r.run_last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function void decode_char(logic [7:0] ch, logic last);
    int         first;
    logic [6:0] sx;
    logic [7:0] b;
    status_t    fin;
    result_t    r;
    first = pending_results.size();
    len_mod = len_mod + 2'd1;
    if (len_mod == 2'd0) len_four = 1'b1;
    if (ch == PAD_CHAR) begin
      if (pads != 2'd3) pads = pads + 2'd1;
    end else begin
      sx = sextet_value(ch);
      if (!sx[6] || pads != 2'd0) begin
        flag_error(ST_CHAR);
      end else if (err == ST_OK) begin
        acc  = {acc[5:0], sx[5:0]};
        held = held + 6;
        if (held >= 8) begin
          held = held - 8;
          b = 8'(acc >> held);
          if (b == QUOTE_CHAR) begin
            push_result(1'b0, ESC_BACKSLASH, ST_OK);
            push_result(1'b0, ESC_X, ST_OK);
            push_result(1'b0, ESC_TWO, ST_OK);
            push_result(1'b0, ESC_TWO, ST_OK);
          end else if (b == TAB_CHAR || b == NL_CHAR || (b >= PRINT_LO && b <= PRINT_HI)) begin
            push_result(1'b0, b, ST_OK);
          end else begin
            flag_error(ST_PRINT);
          end
        end
      end
    end
    if (last) begin
      if (pads > 2'd2) flag_error(ST_CHAR);
      fin = (len_mod != 2'd0 || !len_four) ? ST_LENGTH : err;
      push_result(1'b1, 8'h00, fin);
      clear_string();
    end
    if (pending_results.size() > first) begin
      r = pending_results.pop_back();
      r.run_last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  task report(string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected beat kind=%0d byte=%02h status=%0d last=%0d",
                       got.kind, got.out_byte, got.status, got.run_last));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
        got.status !== want.status || got.run_last !== want.run_last) begin
      report($sformatf("got kind=%0d byte=%02h status=%0d last=%0d, want %0d %02h %0d %0d",
                       got.kind, got.out_byte, got.status, got.run_last,
                       want.kind, want.out_byte, want.status, want.run_last));
    end
  endtask
endclass

module testbench;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int RANDOM_ITEMS    = 280;
  localparam int HOLD_OFF_CYCLES = 80;

  logic clk;
  logic rst;

  b64d_char_if chars_if ();
  b64d_res_if  res_if ();

  text_scoreboard board = new();
  int cycle_count = 0;
  int burst_left = 0;
  int items_sent = 0;
  bit hold_off_req = 1'b0;

  base64_text_decoder i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (res_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[base64_text_decoder] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.kind     = res_if.kind;
      got.out_byte = res_if.out_byte;
      got.status   = status_t'(res_if.status);
      got.run_last = res_if.run_last;
      board.check_result(got);
    end
  end

  initial begin
    int   stall_tick;
    int   mode;
    logic rdy;
    stall_tick = 0;
    mode = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (stall_tick % 64 == 0) mode = $urandom_range(0, 3);
      stall_tick++;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 9) < 7);
        2: rdy = ((stall_tick % 5) >= 2);
        default: rdy = ($urandom_range(0, 9) < 3);
      endcase
      res_if.ready <= rdy;
    end
  end

  function automatic logic [7:0] char_of(logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return "+";
    return "/";
  endfunction

  function automatic octet_q encode_text(octet_q raw);
    octet_q      text;
    logic [23:0] grp;
    int          i;
    int          left;
    for (i = 0; i < raw.size(); i += 3) begin
      left = raw.size() - i;
      grp = {raw[i], (left > 1) ? raw[i+1] : 8'h00, (left > 2) ? raw[i+2] : 8'h00};
      text.push_back(char_of(grp[23:18]));
      text.push_back(char_of(grp[17:12]));
      text.push_back((left > 1) ? char_of(grp[11:6]) : PAD_CHAR);
      text.push_back((left > 2) ? char_of(grp[5:0]) : PAD_CHAR);
    end
    return text;
  endfunction

  function automatic octet_q text_of(string s);
    octet_q t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] random_text_byte();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return QUOTE_CHAR;
    if (sel == 2) return TAB_CHAR;
    if (sel == 3) return NL_CHAR;
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  task automatic pace();
    if (burst_left == 0) begin
      @(negedge clk);
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_char(logic [7:0] ch, logic last);
    @(negedge clk);
    chars_if.valid   <= 1'b1;
    chars_if.in_char <= ch;
    chars_if.in_last <= last;
    do @(posedge clk); while (!chars_if.ready);
    board.decode_char(ch, last);
    items_sent++;
  endtask

  task automatic send_text(octet_q text);
    for (int i = 0; i < text.size(); i++) begin
      pace();
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_string();
    octet_q raw;
    octet_q text;
    int     n;
    int     m;
    int     flavor;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) raw.push_back(random_text_byte());
    flavor = $urandom_range(0, 99);
    if (flavor >= 70 && flavor < 77) raw[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    text = encode_text(raw);
    if (flavor >= 77 && flavor < 83) begin
      if ($urandom_range(0, 1) == 0) void'(text.pop_back());
      else text.push_back(char_of(6'($urandom_range(0, 63))));
    end else if (flavor >= 83 && flavor < 89) begin
      text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (flavor >= 89 && flavor < 94) begin
      text[$urandom_range(0, text.size() - 3)] = PAD_CHAR;
    end else if (flavor >= 94 && flavor < 97) begin
      for (int k = 1; k <= 3; k++) text[text.size() - k] = PAD_CHAR;
    end else if (flavor >= 97) begin
      text.delete();
      m = $urandom_range(1, 8);
      for (int k = 0; k < m; k++) text.push_back(8'($urandom_range(0, 255)));
    end
    send_text(text);
  endtask

  initial begin
    octet_q t;
    int     strings_sent;
    rst = 1'b1;
    chars_if.valid   = 1'b0;
    chars_if.in_char = 8'h00;
    chars_if.in_last = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_text(text_of("IiIi"));
    send_text(text_of("CQo="));
    t = {8'hFF};
    send_text(t);
    send_text(text_of("fn5+"));
    send_text(text_of("/w=="));
    t = {8'h41, PAD_CHAR, 8'h41, 8'h00};
    send_text(t);
    send_text(text_of("A==="));
    pause_until_drained();

    strings_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (strings_sent == 4 || strings_sent == 30) hold_off_req = 1'b1;
      if (strings_sent == 15 || strings_sent == 45) pause_until_drained();
      send_random_string();
      strings_sent++;
    end

    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.fail_count == 0) begin
      $display("[base64_text_decoder] OK");
    end else begin
      $display("[base64_text_decoder] ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_char_if.sv
hw/rtl/b64d_res_if.sv
hw/rtl/b64d_decode.sv
hw/rtl/b64d_emit.sv
hw/rtl/base64_text_decoder.sv
verif/testbench.sv
